@@ rtl/icr_pkg.sv @@
// Package with shared constants and types for the image coordinate refinement block.
`timescale 1ns / 1ps
`default_nettype none
package icr_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PRINCIPAL_POINT = 3'd0,
    REG_RADIAL_K0       = 3'd1,
    REG_RADIAL_K1       = 3'd2,
    REG_RADIAL_K2       = 3'd3,
    REG_RADIAL_K3       = 3'd4,
    REG_DECENTRING      = 3'd5,
    REG_REFRACTION_K    = 3'd6,
    REG_REFRACTION_KC2  = 3'd7
  } cfg_reg_e;

  localparam logic signed [63:0] SMax = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] xp;
    logic signed [31:0] yp;
    logic signed [31:0] k0;
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    logic signed [31:0] kr;
    logic signed [31:0] kc;
  } coeffs_t;

  // Saturating signed 64-bit add to +-(2^63 - 1).
  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    begin
      s = {a[63], a} + {b[63], b};
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) sadd = SMax;
      else if (s < -65'sh0_7FFF_FFFF_FFFF_FFFF) sadd = -SMax;
      else sadd = s[63:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    begin
      if (v > 64'sh7FFF_FFFF) sat32 = 32'sh7FFF_FFFF;
      else if (v < -64'sh8000_0000) sat32 = 32'sh8000_0000;
      else sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] negabs32(input logic signed [63:0] v);
    logic [63:0] m;
    begin
      m = v[63] ? 64'(-v) : 64'(v);
      if (m >= 64'h8000_0000) negabs32 = 32'sh8000_0000;
      else negabs32 = 32'(-$signed(m[31:0]));
    end
  endfunction

  // Magnitude of a signed 64-bit operand.
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

endpackage
`default_nettype wire

@@ rtl/icr_mul.sv @@
// Pipelined exact signed 64x64 multiply, right shift with truncation and saturation.
`timescale 1ns / 1ps
`default_nettype none
module icr_mul #(
  parameter int unsigned Shift = 16
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [63:0] a_i,
  input  wire logic signed [63:0] b_i,
  output logic signed [63:0]      p_o
);
  // Stage 1: magnitudes. Stage 2: four 32x32 partial products.
  // Stage 3: combine, shift and saturate. The stages advance only on enabled cycles.
  logic [63:0] ua_q, ub_q;
  logic        neg1_q, neg2_q;
  logic [63:0] p00_q, p01_q, p10_q, p11_q;

  logic [63:0]  mid;
  logic [127:0] full;
  logic [127:0] shifted;
  logic [63:0]  mag;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ua_q   <= icr_pkg::mag64(a_i);
      ub_q   <= icr_pkg::mag64(b_i);
      neg1_q <= a_i[63] ^ b_i[63];
      p00_q  <= 64'(ua_q[31:0]) * 64'(ub_q[31:0]);
      p01_q  <= 64'(ua_q[31:0]) * 64'(ub_q[63:32]);
      p10_q  <= 64'(ua_q[63:32]) * 64'(ub_q[31:0]);
      p11_q  <= 64'(ua_q[63:32]) * 64'(ub_q[63:32]);
      neg2_q <= neg1_q;
      p_o    <= neg2_q ? -$signed(mag) : $signed(mag);
    end
  end

  always_comb begin
    mid     = 64'(p00_q[63:32]) + 64'(p01_q[31:0]) + 64'(p10_q[31:0]);
    full[31:0]   = p00_q[31:0];
    full[127:32] = 96'(mid) + {32'd0, p01_q[63:32], 32'd0} + {32'd0, p10_q[63:32], 32'd0}
                 + {p11_q, 32'd0};
    shifted = full >> Shift;
    if (shifted[127:63] != '0) mag = icr_pkg::SMax;
    else mag = shifted[63:0];
  end
endmodule
`default_nettype wire

@@ rtl/icr_cfg.sv @@
// Configuration register file for the refinement coefficients.
`timescale 1ns / 1ps
`default_nettype none
module icr_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          we_i,
  input  wire logic [icr_pkg::CfgIdxW-1:0]   idx_i,
  input  wire logic [63:0]                   data_i,
  output icr_pkg::coeffs_t                   coeffs_o
);
  icr_pkg::coeffs_t c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
    end else if (we_i) begin
      case (icr_pkg::cfg_reg_e'(idx_i))
        icr_pkg::REG_PRINCIPAL_POINT: begin
          c_q.xp <= data_i[31:0];
          c_q.yp <= data_i[63:32];
        end
        icr_pkg::REG_RADIAL_K0: c_q.k0 <= data_i[31:0];
        icr_pkg::REG_RADIAL_K1: c_q.k1 <= data_i[31:0];
        icr_pkg::REG_RADIAL_K2: c_q.k2 <= data_i[31:0];
        icr_pkg::REG_RADIAL_K3: c_q.k3 <= data_i[31:0];
        icr_pkg::REG_DECENTRING: begin
          c_q.p1 <= data_i[31:0];
          c_q.p2 <= data_i[63:32];
        end
        icr_pkg::REG_REFRACTION_K:   c_q.kr <= data_i[31:0];
        icr_pkg::REG_REFRACTION_KC2: c_q.kc <= data_i[31:0];
        default: ;
      endcase
    end
  end

  assign coeffs_o = c_q;
endmodule
`default_nettype wire

@@ rtl/image_coordinate_refinement_top.sv @@
// Top level of the image coordinate refinement pipeline.
// Depth: 21 register stages between an accepted point and its offered result word.
// Throughput: one point per cycle while the output is not stalled; the whole pipeline advances together and
// holds on an output stall, including the three-stage 64-bit multiplier units.
// Reset clears coefficient registers and all stage valid bits; payload is not reset.
// The user must write configuration only while the pipeline is empty; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module image_coordinate_refinement_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [31:0] pp_corr_x_o,
  output logic signed [31:0] pp_corr_y_o,
  output logic signed [31:0] radial_corr_x_o,
  output logic signed [31:0] radial_corr_y_o,
  output logic signed [31:0] decent_corr_x_o,
  output logic signed [31:0] decent_corr_y_o,
  output logic signed [31:0] refr_corr_x_o,
  output logic signed [31:0] refr_corr_y_o,
  output logic signed [31:0] fixed_x_o,
  output logic signed [31:0] fixed_y_o
);
  localparam int unsigned Depth = 21;

  icr_pkg::coeffs_t c;
  icr_cfg u_cfg (
    .clk_i, .rst_ni, .we_i(cfg_valid_i), .idx_i(cfg_index_i), .data_i(cfg_data_i),
    .coeffs_o(c)
  );
  assign cfg_ready_o = 1'b1;

  // Global enable: the pipe advances unless a result word waits at the output.
  logic adv;
  logic [Depth-1:0] vld_q;
  assign adv         = !vld_q[Depth-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Depth-2:0], in_valid_i};
  end

  // Stage A: offsets.
  logic signed [63:0] xb_q, yb_q, x_a_q, y_a_q;
  always_ff @(posedge clk_i) if (adv) begin
    xb_q  <= 64'(point_x_i) - 64'(c.xp);
    yb_q  <= 64'(point_y_i) - 64'(c.yp);
    x_a_q <= 64'(point_x_i);
    y_a_q <= 64'(point_y_i);
  end

  // Delay line for values needed later; index 0 is the register after stage A, each higher index one register later.
  logic signed [63:0] xb_d_q [14], yb_d_q [14], xin_q [17], yin_q [17];
  always_ff @(posedge clk_i) if (adv) begin
    xb_d_q[0] <= xb_q; yb_d_q[0] <= yb_q; xin_q[0] <= x_a_q; yin_q[0] <= y_a_q;
    for (int i = 1; i < 14; i++) begin
      xb_d_q[i] <= xb_d_q[i-1]; yb_d_q[i] <= yb_d_q[i-1];
    end
    for (int i = 1; i < 17; i++) begin
      xin_q[i]  <= xin_q[i-1];  yin_q[i]  <= yin_q[i-1];
    end
  end

  // Squares and cross product of the offsets, multiplied from the stage A registers.
  logic signed [63:0] xx, yy, xy;
  icr_mul #(.Shift(16)) u_xx (.clk_i, .en_i(adv), .a_i(xb_q), .b_i(xb_q), .p_o(xx));
  icr_mul #(.Shift(16)) u_yy (.clk_i, .en_i(adv), .a_i(yb_q), .b_i(yb_q), .p_o(yy));
  icr_mul #(.Shift(16)) u_xy (.clk_i, .en_i(adv), .a_i(xb_q), .b_i(yb_q), .p_o(xy));

  // r^2 and decentring operands, registered after the squares (plain wrapping sums).
  logic signed [63:0] r2_q, dxa_q, dya_q, xy2_q;
  always_ff @(posedge clk_i) if (adv) begin
    r2_q  <= xx + yy;
    dxa_q <= xx + yy + (xx <<< 1);
    dya_q <= xx + yy + (yy <<< 1);
    xy2_q <= xy <<< 1;
  end

  // Multipliers fed by r^2 and the decentring operands: r^4, k1 r^2, kc r^2, decentring products.
  logic signed [63:0] r4, k1r2, kcr2, d1, d2, d3, d4;
  icr_mul #(.Shift(16)) u_r4 (.clk_i, .en_i(adv), .a_i(r2_q), .b_i(r2_q), .p_o(r4));
  icr_mul #(.Shift(8))  u_k1 (.clk_i, .en_i(adv), .a_i(64'(c.k1)), .b_i(r2_q), .p_o(k1r2));
  icr_mul #(.Shift(24)) u_kc (.clk_i, .en_i(adv), .a_i(64'(c.kc)), .b_i(r2_q), .p_o(kcr2));
  icr_mul #(.Shift(40)) u_d1 (.clk_i, .en_i(adv), .a_i(64'(c.p1)), .b_i(dxa_q), .p_o(d1));
  icr_mul #(.Shift(40)) u_d2 (.clk_i, .en_i(adv), .a_i(64'(c.p2)), .b_i(xy2_q), .p_o(d2));
  icr_mul #(.Shift(40)) u_d3 (.clk_i, .en_i(adv), .a_i(64'(c.p2)), .b_i(dya_q), .p_o(d3));
  icr_mul #(.Shift(40)) u_d4 (.clk_i, .en_i(adv), .a_i(64'(c.p1)), .b_i(xy2_q), .p_o(d4));

  // r2 delayed through three registers to pair with r4.
  logic signed [63:0] r2_d_q [3];
  always_ff @(posedge clk_i) if (adv) begin
    r2_d_q[0] <= r2_q; r2_d_q[1] <= r2_d_q[0]; r2_d_q[2] <= r2_d_q[1];
  end

  // Multipliers fed by r^4: r^6 and k2 r^4.
  logic signed [63:0] r6, k2r4;
  icr_mul #(.Shift(16)) u_r6 (.clk_i, .en_i(adv), .a_i(r4), .b_i(r2_d_q[2]), .p_o(r6));
  icr_mul #(.Shift(24)) u_k2 (.clk_i, .en_i(adv), .a_i(64'(c.k2)), .b_i(r4), .p_o(k2r4));

  // Partial sums carried along: registered after the r^2 products, then delayed to align with later products.
  logic signed [63:0] pa_q [3], f_q [6], dx_q [10], dy_q [10];
  always_ff @(posedge clk_i) if (adv) begin
    pa_q[0] <= icr_pkg::sadd(64'(c.k0) * 64'sd65536, k1r2);
    pa_q[1] <= pa_q[0];
    pa_q[2] <= pa_q[1];
    f_q[0]  <= icr_pkg::sadd(64'(c.kr) * 64'sd256, kcr2);
    dx_q[0] <= icr_pkg::sadd(d1, d2);
    dy_q[0] <= icr_pkg::sadd(d3, d4);
    for (int i = 1; i < 6; i++) f_q[i] <= f_q[i-1];
    for (int i = 1; i < 10; i++) begin
      dx_q[i] <= dx_q[i-1]; dy_q[i] <= dy_q[i-1];
    end
  end

  // Poly partial sum with k2 r^4, delayed to meet k3 r^6, then the full poly sum.
  logic signed [63:0] pb_q [3], poly_q, k3r6;
  always_ff @(posedge clk_i) if (adv) begin
    pb_q[0] <= icr_pkg::sadd(pa_q[2], k2r4);
    pb_q[1] <= pb_q[0];
    pb_q[2] <= pb_q[1];
    poly_q  <= icr_pkg::sadd(pb_q[2], k3r6);
  end
  icr_mul #(.Shift(40)) u_k3 (.clk_i, .en_i(adv), .a_i(64'(c.k3)), .b_i(r6), .p_o(k3r6));

  // f_q[5] is one register ahead of poly_q; f15_q delays it once more so the
  // refraction multipliers see it aligned with poly_q.
  logic signed [63:0] f15_q;
  always_ff @(posedge clk_i) if (adv) f15_q <= f_q[5];

  // Final products. xb aligned with poly_q is xb_d_q[13].
  logic signed [63:0] rx, ry, fx, fy;
  icr_mul #(.Shift(48)) u_rx (.clk_i, .en_i(adv), .a_i(xb_d_q[13]), .b_i(poly_q), .p_o(rx));
  icr_mul #(.Shift(48)) u_ry (.clk_i, .en_i(adv), .a_i(yb_d_q[13]), .b_i(poly_q), .p_o(ry));
  icr_mul #(.Shift(48)) u_fx (.clk_i, .en_i(adv), .a_i(xb_d_q[13]), .b_i(f15_q), .p_o(fx));
  icr_mul #(.Shift(48)) u_fy (.clk_i, .en_i(adv), .a_i(yb_d_q[13]), .b_i(f15_q), .p_o(fy));

  // Register stage: negabs and pp correction.
  logic signed [31:0] radx_q, rady_q, refx_q, refy_q, decx_q, decy_q, ppx_q, ppy_q;
  logic signed [63:0] x19_q, y19_q;
  always_ff @(posedge clk_i) if (adv) begin
    radx_q <= icr_pkg::negabs32(rx);
    rady_q <= icr_pkg::negabs32(ry);
    refx_q <= icr_pkg::negabs32(fx);
    refy_q <= icr_pkg::negabs32(fy);
    decx_q <= icr_pkg::negabs32(dx_q[9]);
    decy_q <= icr_pkg::negabs32(dy_q[9]);
    ppx_q  <= icr_pkg::sat32(-64'(c.xp));
    ppy_q  <= icr_pkg::sat32(-64'(c.yp));
    x19_q  <= xin_q[16];
    y19_q  <= yin_q[16];
  end

  // Partial sums are registered, then saturated totals go to the output registers.
  logic signed [63:0] sx_q, sy_q, tx_q, ty_q;
  logic signed [31:0] o_q [8];
  always_ff @(posedge clk_i) if (adv) begin
    sx_q <= x19_q + 64'(ppx_q) + 64'(radx_q);
    sy_q <= y19_q + 64'(ppy_q) + 64'(rady_q);
    tx_q <= 64'(decx_q) + 64'(refx_q);
    ty_q <= 64'(decy_q) + 64'(refy_q);
    o_q[0] <= ppx_q;  o_q[1] <= ppy_q;  o_q[2] <= radx_q; o_q[3] <= rady_q;
    o_q[4] <= decx_q; o_q[5] <= decy_q; o_q[6] <= refx_q; o_q[7] <= refy_q;
    pp_corr_x_o     <= o_q[0];
    pp_corr_y_o     <= o_q[1];
    radial_corr_x_o <= o_q[2];
    radial_corr_y_o <= o_q[3];
    decent_corr_x_o <= o_q[4];
    decent_corr_y_o <= o_q[5];
    refr_corr_x_o   <= o_q[6];
    refr_corr_y_o   <= o_q[7];
    fixed_x_o       <= icr_pkg::sat32(sx_q + tx_q);
    fixed_y_o       <= icr_pkg::sat32(sy_q + ty_q);
  end
endmodule
`default_nettype wire
